// File: hdl/lz77_greedy_compressor_defines.svh
// assertion helpers shared by the rtl
`ifndef LZ77_GREEDY_COMPRESSOR_DEFINES_SVH
`define LZ77_GREEDY_COMPRESSOR_DEFINES_SVH

`define LZC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzc check failed");

`define LZC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzc check failed");

`endif

// File: hdl/lzc_pkg.sv
package lzc_pkg;

  localparam int FIELD_W = 13;
  localparam int BYTE_W = 8;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic {
    ST_IDLE,
    ST_WAIT
  } lzc_state_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic token_open;
  } lzc_cell_ctrl_t;

endpackage

// File: hdl/lz77_greedy_compressor.sv
// channel | dir | tdata (low bit up)                         | tlast
// s_*     | in  | data_byte[7:0]                             | last_byte
// m_*     | out | match_offset, match_length, follow_byte, 0s | final_token
// one byte goes through these steps in order: compare in the cell row,
// then a registered max-offset tree over all cells, then the token decision
// rst is synchronous and clears the history valid bits, candidates and token state
// a finished token waits in the output register while the next byte is taken
// a decision that emits a token holds until the output register is free
`include "lz77_greedy_compressor_defines.svh"

module lz77_greedy_compressor #(
  parameter int WINDOW_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // match_offset, match_length, follow_byte, zero pad
  output logic        m_tlast
);

  localparam int OW = $clog2(WINDOW_BYTES + 1);
  localparam int LV = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam int DONE = LV + 1;
  localparam int CW = $clog2(DONE + 1);
  localparam int FW = lzc_pkg::FIELD_W;

  lzc_pkg::lzc_state_t state, state_next;
  logic [CW-1:0] cnt;
  logic [OW-1:0] cur_len;
  logic [OW-1:0] best_off;
  logic          token_open;
  logic          last_q;
  logic [7:0]    byte_q;
  logic [FW-1:0] out_off;
  logic [FW-1:0] out_len;
  logic [7:0]    out_byte;

  logic accept, decide, step, want_emit, emit, out_free, matched;
  logic [OW-1:0] len_new, off_new;
  logic root_hit;
  logic [OW-1:0] root_off;
  lzc_pkg::lzc_cell_ctrl_t ctrl;

  logic [7:0] byte_c [0:WINDOW_BYTES];
  logic       valid_c [0:WINDOW_BYTES];
  logic [WINDOW_BYTES-1:0] hits;

  assign accept = s_tvalid && s_tready;
  assign decide = (state == lzc_pkg::ST_WAIT) && (cnt == CW'(DONE));
  assign matched = root_hit;
  assign len_new = matched ? cur_len + 1'b1 : cur_len;
  assign off_new = matched ? root_off : best_off;
  assign out_free = !m_tvalid || m_tready;
  assign want_emit = decide && (!matched || last_q);
  assign emit = want_emit && out_free;
  assign step = decide && (!want_emit || out_free);

  assign ctrl.shift = accept;
  assign ctrl.clear = emit && last_q;
  assign ctrl.token_open = token_open;

  assign byte_c[0] = s_tdata;
  assign valid_c[0] = 1'b1;

  genvar d;
  generate
    for (d = 1; d <= WINDOW_BYTES; d++) begin : g_cell
      lzc_cell #(.OW(OW)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .len_inc  ({1'b0, cur_len} + 1'b1),
        .offset   (OW'(d)),
        .probe    (s_tdata),
        .byte_in  (byte_c[d-1]),
        .valid_in (valid_c[d-1]),
        .byte_out (byte_c[d]),
        .valid_out(valid_c[d]),
        .hit      (hits[d-1])
      );
    end
  endgenerate

  lzc_tree #(.W(WINDOW_BYTES), .OW(OW)) u_tree (
    .clk     (clk),
    .leaves  (hits),
    .root_hit(root_hit),
    .root_off(root_off)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    unique case (state)
      lzc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = lzc_pkg::ST_WAIT;
        end
      end
      lzc_pkg::ST_WAIT: begin
        if (step) begin
          state_next = lzc_pkg::ST_IDLE;
        end
      end
      default: state_next = lzc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      cur_len <= '0;
      best_off <= '0;
      token_open <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        cnt <= '0;
        token_open <= 1'b1;
      end else if (state == lzc_pkg::ST_WAIT && !decide) begin
        cnt <= cnt + 1'b1;
      end
      if (step) begin
        if (emit) begin
          cur_len <= '0;
          best_off <= '0;
          token_open <= 1'b0;
        end else begin
          cur_len <= len_new;
          best_off <= off_new;
        end
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= s_tdata;
      last_q <= s_tlast;
    end
    if (emit) begin
      out_off <= FW'(off_new);
      out_len <= FW'(len_new);
      out_byte <= matched ? 8'd0 : byte_q;
      m_tlast <= last_q;
    end
  end

  assign m_tdata = {6'd0, out_byte, out_len, out_off};

  `LZC_ASSERT_SAME(a_emit_has_room, emit, !m_tvalid || m_tready)
  `LZC_ASSERT_SAME(a_len_le_off, m_tvalid && (WINDOW_BYTES < 8192), out_len <= out_off)
  `LZC_ASSERT_NEXT(a_final_clears, emit && last_q, !valid_c[1] && !token_open)

endmodule

// File: hdl/lzc_cell.sv
module lzc_cell #(
  parameter int OW = 13
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lzc_pkg::lzc_cell_ctrl_t   ctrl,
  input  logic [OW:0]               len_inc,
  input  logic [OW-1:0]             offset,
  input  logic [lzc_pkg::BYTE_W-1:0] probe,
  input  logic [lzc_pkg::BYTE_W-1:0] byte_in,
  input  logic                      valid_in,
  output logic [lzc_pkg::BYTE_W-1:0] byte_out,
  output logic                      valid_out,
  output logic                      hit
);

  logic [lzc_pkg::BYTE_W-1:0] hist;
  logic valid;
  logic active;
  logic live;
  logic match;

  assign live = ctrl.token_open ? active : valid;
  assign match = live && (hist == probe);
  assign byte_out = hist;
  assign valid_out = valid;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      hist <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      hit <= 1'b0;
    end else if (ctrl.shift) begin
      // candidate retires once it has copied as many bytes as its offset
      active <= match && ({1'b0, offset} > len_inc);
      hit <= match;
    end
  end

endmodule

// File: hdl/lzc_tree.sv
module lzc_tree #(
  parameter int W = 4096,
  parameter int OW = 13
) (
  input  logic          clk,
  input  logic [W-1:0]  leaves,
  output logic          root_hit,
  output logic [OW-1:0] root_off
);

  localparam int LV = (W > 1) ? $clog2(W) : 1;
  localparam int NP = 2 ** LV;
  localparam int TW = $clog2(NP + 1);

  logic          hit_n [1:2*NP-1];
  logic [TW-1:0] off_n [1:2*NP-1];

  genvar i;
  generate
    for (i = 0; i < NP; i++) begin : g_leaf
      always_ff @(posedge clk) begin
        hit_n[NP+i] <= (i < W) ? leaves[(i < W) ? i : 0] : 1'b0;
        off_n[NP+i] <= TW'(i + 1);
      end
    end
    for (i = 1; i < NP; i++) begin : g_node
      // larger offset wins on ties
      always_ff @(posedge clk) begin
        hit_n[i] <= hit_n[2*i] || hit_n[2*i+1];
        off_n[i] <= hit_n[2*i+1] ? off_n[2*i+1] : off_n[2*i];
      end
    end
  endgenerate

  assign root_hit = hit_n[1];
  assign root_off = OW'(off_n[1]);

endmodule
